### src/poq_pkg.sv
// Shared types and constants for the priority operation queue.
package poq_pkg;

  localparam logic [1:0] MODE_ENQ = 2'd0;
  localparam logic [1:0] MODE_POP = 2'd1;
  localparam logic [1:0] MODE_UPD = 2'd2;
  localparam logic [1:0] MODE_FIND = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_ZERO = 3'd1;
  localparam logic [2:0] ST_DUP = 3'd2;
  localparam logic [2:0] ST_NONE = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;

  localparam logic [2:0] LIFE_QUEUED = 3'd2;
  localparam logic [2:0] LIFE_STARTED = 3'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [63:0] op_id;
    logic signed [31:0] prio;
    logic [2:0] op_kind;
    logic [63:0] resource_ref;
    logic [63:0] revision_ref;
    logic [2:0] new_state;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [63:0] out_id;
    logic signed [31:0] out_prio;
    logic [2:0] out_kind;
    logic [63:0] out_resource;
    logic [63:0] out_revision;
    logic [2:0] out_state;
    logic [4:0] pending_count;
  } rsp_t;

  typedef struct packed {
    logic [63:0] id;
    logic signed [31:0] prio;
    logic [2:0] kind;
    logic [63:0] resource;
    logic [63:0] revision;
    logic [2:0] life;
  } entry_t;

  // Token passed along the cell chain during a scan.
  typedef struct packed {
    logic hit;
    logic have_best;
    logic signed [31:0] best_prio;
    logic [63:0] key;
  } scan_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic write;
    logic set_life;
    logic [2:0] life;
    logic remove;
    entry_t data;
  } cell_cmd_t;

endpackage

### src/poq_cell.sv
// One table cell: stores an entry, its pending rank, and joins the scan chain.
module poq_cell #(
  parameter int RW = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sel_write,
  input  logic                 sel_hit,
  input  logic                 sel_best,
  input  logic [RW-1:0]        new_rank,
  input  logic [RW-1:0]        removed_rank,
  input  poq_pkg::cell_cmd_t   cmd,
  input  poq_pkg::scan_t       scan_in,
  output poq_pkg::scan_t       scan_out,
  output logic                 is_hit,
  output logic                 is_best,
  output logic                 used,
  output poq_pkg::entry_t      data
);

  logic pending;
  logic [RW-1:0] rank;
  logic match;

  assign match = used && (data.id == scan_in.key);
  assign is_hit = match && !scan_in.hit;
  assign is_best = used && pending;

  always_comb begin
    scan_out = scan_in;
    if (match) begin
      scan_out.hit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
      pending <= 1'b0;
    end else begin
      if (sel_write && cmd.write) begin
        used <= 1'b1;
        pending <= 1'b1;
        rank <= new_rank;
        data <= cmd.data;
      end
      if (sel_hit && cmd.set_life) begin
        data.life <= cmd.life;
      end
      if (cmd.remove && pending) begin
        if (sel_best) begin
          pending <= 1'b0;
          data.life <= poq_pkg::LIFE_STARTED;
        end else if (rank > removed_rank) begin
          rank <= rank - RW'(1);
        end
      end
    end
  end

endmodule

### src/poq_scan.sv
// Registered scan over the cells with oldest-first tie breaking by rank.
module poq_scan #(
  parameter int N = 16,
  parameter int RW = 5
) (
  input  logic                      clk,
  input  logic                      start,
  input  logic [63:0]               key,
  input  logic [N-1:0]              cell_hit,
  input  logic [N-1:0]              cell_pend,
  input  logic signed [31:0]        prio [N],
  input  logic [RW-1:0]             rank [N],
  output logic [N-1:0]              hit_sel,
  output logic [N-1:0]              best_sel,
  output logic                      any_hit,
  output logic                      any_best
);

  localparam int LW = (N > 1) ? $clog2(N) : 1;
  localparam int P = 1 << LW;

  // First-hit one-hot, and the best pending cell found by a compare tree.
  logic [N-1:0] hs;
  logic [N-1:0] bs;
  logic found;
  logic bf;
  logic nv [2*P];
  logic signed [31:0] np [2*P];
  logic [RW-1:0] nr [2*P];
  logic [LW-1:0] ni [2*P];

  always_comb begin
    hs = '0;
    found = 1'b0;
    for (int i = 0; i < N; i++) begin
      if (cell_hit[i] && !found) begin
        hs[i] = 1'b1;
        found = 1'b1;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 2 * P; k++) begin
      nv[k] = 1'b0;
      np[k] = '0;
      nr[k] = '0;
      ni[k] = '0;
    end
    for (int i = 0; i < N; i++) begin
      nv[P+i] = cell_pend[i];
      np[P+i] = prio[i];
      nr[P+i] = rank[i];
      ni[P+i] = LW'(i);
    end
    for (int k = P - 1; k >= 1; k--) begin
      if (nv[2*k] && (!nv[2*k+1] || np[2*k] > np[2*k+1] ||
          (np[2*k] == np[2*k+1] && nr[2*k] < nr[2*k+1]))) begin
        nv[k] = 1'b1;
        np[k] = np[2*k];
        nr[k] = nr[2*k];
        ni[k] = ni[2*k];
      end else begin
        nv[k] = nv[2*k+1];
        np[k] = np[2*k+1];
        nr[k] = nr[2*k+1];
        ni[k] = ni[2*k+1];
      end
    end
    bs = '0;
    bs[ni[1]] = nv[1];
    bf = nv[1];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hit_sel <= hs;
      best_sel <= bs;
      any_hit <= found;
      any_best <= bf;
    end
  end

  logic unused_key;
  assign unused_key = ^{key, nv[0], np[0], nr[0], ni[0]};

endmodule

### src/priority_operation_queue.sv
// Top level of the priority operation queue: cell row plus control sequencer.
// A request is registered in the idle state, scanned in the compare state and applied in the update state.
// A new request is taken only in the idle state, so each one passes the compare, update and output states first.
// A stalled result holds the block in its output state and keeps the input stalled.
// Reset clears all valid and pending bits and the pending count.
module priority_operation_queue #(
  parameter int CAPACITY = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  poq_pkg::req_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output poq_pkg::rsp_t   out_data
);

  localparam int RW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP = 2'd1;
  localparam logic [1:0] S_ACT = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;

  logic [1:0] state;
  poq_pkg::req_t req;
  logic [RW-1:0] used_cnt;
  logic [RW-1:0] plen;

  logic [CAPACITY-1:0] hit_v, used_v, best_v;
  logic [CAPACITY-1:0] hit_sel, best_sel, pend_v;
  logic any_hit, any_best;
  logic signed [31:0] prio_a [CAPACITY];
  logic [RW-1:0] rank_a [CAPACITY];
  poq_pkg::entry_t data_a [CAPACITY];
  poq_pkg::scan_t chain [CAPACITY+1];
  poq_pkg::cell_cmd_t cmd;
  logic [RW-1:0] removed_rank;
  poq_pkg::rsp_t rsp;
  poq_pkg::rsp_t rsp_next;
  logic [CAPACITY-1:0] wsel;

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data = rsp;

  assign chain[0] = '{hit: 1'b0, have_best: 1'b0, best_prio: '0, key: req.op_id};

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      assign wsel[g] = (used_cnt[IW-1:0] == IW'(g)) && (used_cnt < RW'(CAPACITY));
      poq_cell #(.RW(RW)) u_cell (
        .clk(clk), .rst(rst),
        .sel_write(wsel[g]), .sel_hit(hit_sel[g]), .sel_best(best_sel[g]),
        .new_rank(plen), .removed_rank(removed_rank), .cmd(cmd),
        .scan_in(chain[g]), .scan_out(chain[g+1]),
        .is_hit(hit_v[g]), .is_best(best_v[g]), .used(used_v[g]), .data(data_a[g])
      );
      assign pend_v[g] = best_v[g];
      assign prio_a[g] = data_a[g].prio;
      assign rank_a[g] = u_cell.rank;
    end
  endgenerate

  poq_scan #(.N(CAPACITY), .RW(RW)) u_scan (
    .clk(clk), .start(state == S_CMP), .key(req.op_id),
    .cell_hit(hit_v), .cell_pend(pend_v), .prio(prio_a), .rank(rank_a),
    .hit_sel(hit_sel), .best_sel(best_sel), .any_hit(any_hit), .any_best(any_best)
  );

  always_comb begin
    removed_rank = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (best_sel[i]) begin
        removed_rank = rank_a[i];
      end
    end
  end

  logic enq_ok;
  assign enq_ok = (req.mode == poq_pkg::MODE_ENQ) && (req.op_id != 64'd0) && !any_hit &&
                  (used_cnt < RW'(CAPACITY));

  always_comb begin
    cmd = '0;
    cmd.data = '{id: req.op_id, prio: req.prio, kind: req.op_kind,
                 resource: req.resource_ref, revision: req.revision_ref,
                 life: poq_pkg::LIFE_QUEUED};
    cmd.life = req.new_state;
    if (state == S_ACT) begin
      cmd.write = enq_ok;
      cmd.set_life = (req.mode == poq_pkg::MODE_UPD) && any_hit;
      cmd.remove = (req.mode == poq_pkg::MODE_POP) && any_best;
    end
  end

  always_comb begin
    rsp_next = '0;
    unique case (req.mode)
      poq_pkg::MODE_ENQ: begin
        if (req.op_id == 64'd0) begin
          rsp_next.status = poq_pkg::ST_ZERO;
        end else if (any_hit) begin
          rsp_next.status = poq_pkg::ST_DUP;
        end else if (used_cnt >= RW'(CAPACITY)) begin
          rsp_next.status = poq_pkg::ST_FULL;
        end else begin
          rsp_next.status = poq_pkg::ST_OK;
        end
        rsp_next.pending_count = 5'(enq_ok ? plen + RW'(1) : plen);
      end
      poq_pkg::MODE_POP: begin
        rsp_next.pending_count = 5'(any_best ? plen - RW'(1) : plen);
        if (!any_best) begin
          rsp_next.status = poq_pkg::ST_NONE;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (best_sel[i]) begin
              rsp_next.out_id = data_a[i].id;
              rsp_next.out_prio = data_a[i].prio;
              rsp_next.out_kind = data_a[i].kind;
              rsp_next.out_resource = data_a[i].resource;
              rsp_next.out_revision = data_a[i].revision;
            end
          end
          rsp_next.out_state = poq_pkg::LIFE_STARTED;
        end
      end
      poq_pkg::MODE_UPD: begin
        rsp_next.pending_count = 5'(plen);
        rsp_next.status = any_hit ? poq_pkg::ST_OK : poq_pkg::ST_NONE;
      end
      poq_pkg::MODE_FIND: begin
        rsp_next.pending_count = 5'(plen);
        if (!any_hit) begin
          rsp_next.status = poq_pkg::ST_NONE;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (hit_sel[i]) begin
              rsp_next.out_id = data_a[i].id;
              rsp_next.out_prio = data_a[i].prio;
              rsp_next.out_kind = data_a[i].kind;
              rsp_next.out_resource = data_a[i].resource;
              rsp_next.out_revision = data_a[i].revision;
              rsp_next.out_state = data_a[i].life;
            end
          end
        end
      end
      default: rsp_next.status = poq_pkg::ST_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used_cnt <= '0;
      plen <= '0;
      req <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req <= in_data;
            state <= S_CMP;
          end
        end
        S_CMP: state <= S_ACT;
        S_ACT: begin
          rsp <= rsp_next;
          state <= S_OUT;
          if (enq_ok) begin
            used_cnt <= used_cnt + RW'(1);
            plen <= plen + RW'(1);
          end else if ((req.mode == poq_pkg::MODE_POP) && any_best) begin
            plen <= plen - RW'(1);
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic unused_sig;
  assign unused_sig = ^{used_v, chain[CAPACITY]};

endmodule

### tb/priority_operation_queue_test.sv
// Testbench for the priority operation queue: random and directed requests.
`timescale 1ns / 100ps

module priority_operation_queue_test;

  localparam int SLOTS = 16;
  localparam int IDLE_LIMIT = 4000;

  class queue_scoreboard;
    poq_pkg::entry_t table_q[$];
    int pend_q[$];
    poq_pkg::rsp_t answers[$];
    int mismatches;

    function void note_request(poq_pkg::req_t r);
      poq_pkg::rsp_t a;
      poq_pkg::entry_t e;
      int hit;
      int best;
      a = '0;
      a.status = poq_pkg::ST_OK;
      hit = -1;
      if (r.mode != poq_pkg::MODE_POP) begin
        foreach (table_q[i]) begin
          if (table_q[i].id == r.op_id) begin
            hit = i;
          end
        end
      end
      case (r.mode)
        poq_pkg::MODE_ENQ: begin
          if (r.op_id == 64'd0) begin
            a.status = poq_pkg::ST_ZERO;
          end else if (hit >= 0) begin
            a.status = poq_pkg::ST_DUP;
          end else if (table_q.size() >= SLOTS) begin
            a.status = poq_pkg::ST_FULL;
          end else begin
            e = {r.op_id, r.prio, r.op_kind, r.resource_ref, r.revision_ref,
                 poq_pkg::LIFE_QUEUED};
            table_q = {table_q, e};
            pend_q = {pend_q, table_q.size() - 1};
          end
        end
        poq_pkg::MODE_POP: begin
          if (pend_q.size() == 0) begin
            a.status = poq_pkg::ST_NONE;
          end else begin
            best = 0;
            foreach (pend_q[i]) begin
              if (table_q[pend_q[i]].prio > table_q[pend_q[best]].prio) begin
                best = i;
              end
            end
            hit = pend_q[best];
            pend_q.delete(best);
            table_q[hit].life = poq_pkg::LIFE_STARTED;
            {a.out_id, a.out_prio, a.out_kind, a.out_resource, a.out_revision,
             a.out_state} = table_q[hit];
          end
        end
        poq_pkg::MODE_UPD: begin
          if (hit < 0) begin
            a.status = poq_pkg::ST_NONE;
          end else begin
            table_q[hit].life = r.new_state;
          end
        end
        default: begin
          if (hit < 0) begin
            a.status = poq_pkg::ST_NONE;
          end else begin
            {a.out_id, a.out_prio, a.out_kind, a.out_resource, a.out_revision,
             a.out_state} = table_q[hit];
          end
        end
      endcase
      a.pending_count = 5'(pend_q.size());
      answers = {answers, a};
    endfunction

    function void check_answer(poq_pkg::rsp_t got);
      poq_pkg::rsp_t want;
      if (answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected result %h", got);
        end
        return;
      end
      want = answers.pop_front();
      if (got.status !== want.status || got.out_id !== want.out_id
          || got.out_prio !== want.out_prio || got.out_kind !== want.out_kind
          || got.out_resource !== want.out_resource
          || got.out_revision !== want.out_revision
          || got.out_state !== want.out_state
          || got.pending_count !== want.pending_count) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Result mismatch: expected %h, got %h", want, got);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  poq_pkg::req_t in_data;
  logic out_valid;
  logic out_stall;
  poq_pkg::rsp_t out_data;

  queue_scoreboard board;
  logic [63:0] used_ids[$];
  int idle_cycles;

  priority_operation_queue dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] wide_random();
    case ($urandom_range(0, 3))
      0: return 64'd0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] pick_id();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1, 2: return wide_random();
      default: begin
        if (used_ids.size() == 0) begin
          return {$urandom, $urandom};
        end
        return used_ids[$urandom_range(0, used_ids.size() - 1)];
      end
    endcase
  endfunction

  task automatic send_request(poq_pkg::req_t r);
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    board.note_request(r);
    if (r.mode == poq_pkg::MODE_ENQ) begin
      used_ids = {used_ids, r.op_id};
    end
  endtask

  task automatic pause_sender(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic poq_pkg::req_t make_request(logic [1:0] m, logic [63:0] id,
                                                 logic signed [31:0] p);
    poq_pkg::req_t r;
    r.mode = m;
    r.op_id = id;
    r.prio = p;
    r.op_kind = 3'($urandom_range(0, 7));
    r.resource_ref = wide_random();
    r.revision_ref = wide_random();
    r.new_state = 3'($urandom_range(0, 7));
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        board.check_answer(out_data);
      end
      out_stall <= ($urandom_range(0, 3) == 0) && ($urandom_range(0, 255) > 60);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    poq_pkg::req_t r;
    int burst;
    int m;
    board = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty pop, zero id, extremes of priority, ties, duplicates.
    send_request(make_request(poq_pkg::MODE_POP, 64'd0, 32'sd0));
    send_request(make_request(poq_pkg::MODE_FIND, 64'd0, 32'sd0));
    send_request(make_request(poq_pkg::MODE_UPD, 64'd0, 32'sd0));
    send_request(make_request(poq_pkg::MODE_ENQ, 64'd0, 32'sd5));
    send_request(make_request(poq_pkg::MODE_ENQ, '1, 32'h8000_0000));
    send_request(make_request(poq_pkg::MODE_ENQ, 64'd1, 32'h7fff_ffff));
    send_request(make_request(poq_pkg::MODE_ENQ, 64'd2, 32'h7fff_ffff));
    send_request(make_request(poq_pkg::MODE_ENQ, 64'd1, 32'sd0));
    send_request(make_request(poq_pkg::MODE_UPD, 64'd2, 32'sd0));
    send_request(make_request(poq_pkg::MODE_FIND, 64'd2, 32'sd0));
    send_request(make_request(poq_pkg::MODE_FIND, '1, 32'sd0));
    send_request(make_request(poq_pkg::MODE_POP, 64'd0, 32'sd0));
    send_request(make_request(poq_pkg::MODE_POP, 64'd0, 32'sd0));
    send_request(make_request(poq_pkg::MODE_FIND, 64'd1, 32'sd0));
    send_request(make_request(poq_pkg::MODE_POP, 64'd0, 32'sd0));
    send_request(make_request(poq_pkg::MODE_POP, 64'd0, 32'sd0));

    // Random part: the table fills early, so later enqueues mostly see a full table.
    for (int n = 0; n < 900; ) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst; b++, n++) begin
        m = $urandom_range(0, 9);
        if (m < 4) begin
          r = make_request(poq_pkg::MODE_ENQ, ($urandom_range(0, 5) == 0) ? pick_id()
                           : {$urandom, $urandom}, ($urandom_range(0, 3) == 0)
                           ? $urandom_range(0, 3) : $urandom);
        end else if (m < 6) begin
          r = make_request(poq_pkg::MODE_POP, wide_random(), $urandom);
        end else if (m < 8) begin
          r = make_request(poq_pkg::MODE_UPD, pick_id(), $urandom);
        end else begin
          r = make_request(poq_pkg::MODE_FIND, pick_id(), $urandom);
        end
        send_request(r);
      end
      if ($urandom_range(0, 2) != 0) begin
        pause_sender($urandom_range(1, 12));
      end
    end
    in_valid <= 1'b0;

    while (board.answers.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
